@@ src/cau_pkg.sv @@
// Package for the complex arithmetic unit: item types, command codes and
// fixed-point widths. Used by complex_arithmetic_unit; depends on nothing.
`default_nettype none
package cau_pkg;

	// fixed-point format of every operand and result part
	localparam int FRAC_BITS = 8;
	localparam int DW        = 16;

	// internal widths
	localparam int PW   = 2 * DW;             // one product
	localparam int SW   = PW + 1;             // sum of two products
	localparam int DENW = PW;                 // |b|^2, unsigned
	localparam int MAGW = PW;                 // |numerator|, unsigned
	localparam int NW   = MAGW + FRAC_BITS + 1; // scaled dividend
	localparam int DDW  = DENW + 1;           // doubled divisor
	localparam int QW   = DW;                 // quotient bits kept before clamp
	localparam int CW   = DDW + QW;           // compare width in the divider
	localparam int MW   = SW + 1;             // multiply rounding width

	// round half up constant for the multiply
	localparam logic signed [MW-1:0] MUL_RND = (FRAC_BITS > 0) ?
		(MW'(1) <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;

	// command codes
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_CMP = 3'd4;

	typedef struct packed {
		logic [2:0]           cmd;
		logic signed [DW-1:0] a_re;
		logic signed [DW-1:0] a_im;
		logic signed [DW-1:0] b_re;
		logic signed [DW-1:0] b_im;
	} in_item_t;

	typedef struct packed {
		logic signed [DW-1:0] res_re;
		logic signed [DW-1:0] res_im;
		logic                 equal;
		logic                 div_zero;
		logic                 saturated;
	} out_item_t;

endpackage
`default_nettype wire

@@ src/complex_arithmetic_unit.sv @@
// Complex arithmetic unit top level: add, subtract, multiply, divide and
// compare on Q8.8 complex operands. Depends on cau_pkg.
//
//   channel | signals                          | payload
//   input   | in_valid, in_ready, in_data      | cau_pkg::in_item_t
//   output  | out_valid, out_ready, out_data   | cau_pkg::out_item_t
//
// One item enters per cycle while in_ready is high; each item passes 21 register
// stages (3 product/sum/rounding stages; 17 divider stages, the first checking
// overflow and the rest giving one quotient bit each; 1 output).
// Every command passes all stages; the 16-bit restoring divider sets their number.
// Reset clears only the stage valid bits. A stalled output holds every full stage
// behind it while empty stages keep filling, so nothing is lost or repeated.
`default_nettype none
module complex_arithmetic_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cau_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cau_pkg::out_item_t      out_data
);

	localparam int NS  = cau_pkg::QW + 5;
	localparam int DV0 = 3;

	typedef struct packed {
		logic [2:0]                    cmd;
		logic signed [cau_pkg::DW-1:0] res_re;
		logic signed [cau_pkg::DW-1:0] res_im;
		logic                          equal;
		logic                          saturated;
		logic signed [cau_pkg::PW-1:0] p_rr;
		logic signed [cau_pkg::PW-1:0] p_ii;
		logic signed [cau_pkg::PW-1:0] p_ri;
		logic signed [cau_pkg::PW-1:0] p_ir;
		logic signed [cau_pkg::PW-1:0] sq_r;
		logic signed [cau_pkg::PW-1:0] sq_i;
	} st1_t;

	typedef struct packed {
		logic [2:0]                    cmd;
		logic signed [cau_pkg::DW-1:0] res_re;
		logic signed [cau_pkg::DW-1:0] res_im;
		logic                          equal;
		logic                          saturated;
		logic signed [cau_pkg::SW-1:0] m_re;
		logic signed [cau_pkg::SW-1:0] m_im;
		logic signed [cau_pkg::SW-1:0] n_re;
		logic signed [cau_pkg::SW-1:0] n_im;
		logic [cau_pkg::DENW-1:0]      den;
	} st2_t;

	typedef struct packed {
		logic [2:0]                    cmd;
		logic signed [cau_pkg::DW-1:0] res_re;
		logic signed [cau_pkg::DW-1:0] res_im;
		logic                          equal;
		logic                          div_zero;
		logic                          saturated;
		logic                          neg_re;
		logic                          neg_im;
		logic                          ovf_re;
		logic                          ovf_im;
		logic [cau_pkg::NW-1:0]        rem_re;
		logic [cau_pkg::NW-1:0]        rem_im;
		logic [cau_pkg::DDW-1:0]       dvs;
		logic [cau_pkg::QW-1:0]        q_re;
		logic [cau_pkg::QW-1:0]        q_im;
	} dv_t;

	// clamp to the signed 16-bit range; top bit is the clamp flag
	function automatic logic [cau_pkg::DW:0] clamp16(input logic signed [cau_pkg::MW-1:0] v);
		logic signed [cau_pkg::MW-1:0] hi;
		logic signed [cau_pkg::MW-1:0] lo;
		hi = cau_pkg::MW'(32767);
		lo = -cau_pkg::MW'(32768);
		if (v > hi)
			return {1'b1, 16'sh7fff};
		else if (v < lo)
			return {1'b1, 16'sh8000};
		else
			return {1'b0, v[cau_pkg::DW-1:0]};
	endfunction

	logic [NS-1:0] vld_q;
	logic [NS-1:0] rdy;
	st1_t          st_s1, st1_d;
	st2_t          st_s2, st2_d;
	dv_t           st_s3, st3_d;
	dv_t           dv_s   [cau_pkg::QW+1];
	dv_t           dv_d   [cau_pkg::QW+1];
	cau_pkg::out_item_t out_q, out_d;

	// ready chain: a stage takes new data when empty or when it drains
	always_comb begin
		rdy[NS-1] = !vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NS-1];
	assign out_data  = out_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0])
				vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: products, add/sub, compare
	always_comb begin
		logic [cau_pkg::DW:0] c_re;
		logic [cau_pkg::DW:0] c_im;
		logic signed [cau_pkg::DW:0] s_re;
		logic signed [cau_pkg::DW:0] s_im;
		st1_d.cmd  = in_data.cmd;
		st1_d.p_rr = cau_pkg::PW'(in_data.a_re * in_data.b_re);
		st1_d.p_ii = cau_pkg::PW'(in_data.a_im * in_data.b_im);
		st1_d.p_ri = cau_pkg::PW'(in_data.a_re * in_data.b_im);
		st1_d.p_ir = cau_pkg::PW'(in_data.a_im * in_data.b_re);
		st1_d.sq_r = cau_pkg::PW'(in_data.b_re * in_data.b_re);
		st1_d.sq_i = cau_pkg::PW'(in_data.b_im * in_data.b_im);
		if (in_data.cmd == cau_pkg::CMD_SUB) begin
			s_re = (cau_pkg::DW+1)'(in_data.a_re) - (cau_pkg::DW+1)'(in_data.b_re);
			s_im = (cau_pkg::DW+1)'(in_data.a_im) - (cau_pkg::DW+1)'(in_data.b_im);
		end else begin
			s_re = (cau_pkg::DW+1)'(in_data.a_re) + (cau_pkg::DW+1)'(in_data.b_re);
			s_im = (cau_pkg::DW+1)'(in_data.a_im) + (cau_pkg::DW+1)'(in_data.b_im);
		end
		c_re = clamp16(cau_pkg::MW'(s_re));
		c_im = clamp16(cau_pkg::MW'(s_im));
		st1_d.res_re    = '0;
		st1_d.res_im    = '0;
		st1_d.saturated = 1'b0;
		st1_d.equal     = 1'b0;
		case (in_data.cmd)
			cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
				st1_d.res_re    = c_re[cau_pkg::DW-1:0];
				st1_d.res_im    = c_im[cau_pkg::DW-1:0];
				st1_d.saturated = c_re[cau_pkg::DW] | c_im[cau_pkg::DW];
			end
			cau_pkg::CMD_CMP: begin
				st1_d.equal = (in_data.a_re == in_data.b_re) &&
					(in_data.a_im == in_data.b_im);
			end
			default: begin
			end
		endcase
	end

	// stage 2: sums of products
	always_comb begin
		st2_d.cmd       = st_s1.cmd;
		st2_d.res_re    = st_s1.res_re;
		st2_d.res_im    = st_s1.res_im;
		st2_d.equal     = st_s1.equal;
		st2_d.saturated = st_s1.saturated;
		st2_d.m_re = cau_pkg::SW'(st_s1.p_rr) - cau_pkg::SW'(st_s1.p_ii);
		st2_d.m_im = cau_pkg::SW'(st_s1.p_ri) + cau_pkg::SW'(st_s1.p_ir);
		st2_d.n_re = cau_pkg::SW'(st_s1.p_rr) + cau_pkg::SW'(st_s1.p_ii);
		st2_d.n_im = cau_pkg::SW'(st_s1.p_ir) - cau_pkg::SW'(st_s1.p_ri);
		st2_d.den  = cau_pkg::DENW'(st_s1.sq_r) + cau_pkg::DENW'(st_s1.sq_i);
	end

	// stage 3: multiply rounding, divider operand setup
	always_comb begin
		logic signed [cau_pkg::MW-1:0] r_re;
		logic signed [cau_pkg::MW-1:0] r_im;
		logic [cau_pkg::DW:0]          c_re;
		logic [cau_pkg::DW:0]          c_im;
		logic [cau_pkg::SW-1:0]        mag_re;
		logic [cau_pkg::SW-1:0]        mag_im;
		r_re = (cau_pkg::MW'(st_s2.m_re) + cau_pkg::MUL_RND) >>> cau_pkg::FRAC_BITS;
		r_im = (cau_pkg::MW'(st_s2.m_im) + cau_pkg::MUL_RND) >>> cau_pkg::FRAC_BITS;
		c_re = clamp16(r_re);
		c_im = clamp16(r_im);
		mag_re = st_s2.n_re[cau_pkg::SW-1] ? -st_s2.n_re : st_s2.n_re;
		mag_im = st_s2.n_im[cau_pkg::SW-1] ? -st_s2.n_im : st_s2.n_im;
		st3_d.cmd       = st_s2.cmd;
		st3_d.equal     = st_s2.equal;
		st3_d.res_re    = st_s2.res_re;
		st3_d.res_im    = st_s2.res_im;
		st3_d.saturated = st_s2.saturated;
		st3_d.div_zero  = (st_s2.cmd == cau_pkg::CMD_DIV) && (st_s2.den == '0);
		st3_d.neg_re    = st_s2.n_re[cau_pkg::SW-1];
		st3_d.neg_im    = st_s2.n_im[cau_pkg::SW-1];
		st3_d.ovf_re    = 1'b0;
		st3_d.ovf_im    = 1'b0;
		st3_d.rem_re = {mag_re[cau_pkg::MAGW-1:0], (cau_pkg::FRAC_BITS+1)'(0)} +
			cau_pkg::NW'(st_s2.den);
		st3_d.rem_im = {mag_im[cau_pkg::MAGW-1:0], (cau_pkg::FRAC_BITS+1)'(0)} +
			cau_pkg::NW'(st_s2.den);
		st3_d.dvs  = {st_s2.den, 1'b0};
		st3_d.q_re = '0;
		st3_d.q_im = '0;
		if (st_s2.cmd == cau_pkg::CMD_MUL) begin
			st3_d.res_re    = c_re[cau_pkg::DW-1:0];
			st3_d.res_im    = c_im[cau_pkg::DW-1:0];
			st3_d.saturated = c_re[cau_pkg::DW] | c_im[cau_pkg::DW];
		end
	end

	// divider: first stage checks overflow, then one quotient bit per stage
	for (genvar j = 0; j <= cau_pkg::QW; j++) begin : g_div
		always_comb begin
			dv_t                    src;
			logic [cau_pkg::CW-1:0] sh;
			logic [cau_pkg::CW-1:0] xr;
			logic [cau_pkg::CW-1:0] xi;
			if (j == 0)
				src = st_s3;
			else
				src = dv_s[(j == 0) ? 0 : j-1];
			sh = cau_pkg::CW'(src.dvs) << (cau_pkg::QW - j);
			xr = cau_pkg::CW'(src.rem_re);
			xi = cau_pkg::CW'(src.rem_im);
			dv_d[j] = src;
			if (j == 0) begin
				dv_d[j].ovf_re = (xr >= sh);
				dv_d[j].ovf_im = (xi >= sh);
			end else begin
				if (xr >= sh) begin
					dv_d[j].rem_re = cau_pkg::NW'(xr - sh);
					dv_d[j].q_re[(j == 0) ? 0 : cau_pkg::QW-j] = 1'b1;
				end
				if (xi >= sh) begin
					dv_d[j].rem_im = cau_pkg::NW'(xi - sh);
					dv_d[j].q_im[(j == 0) ? 0 : cau_pkg::QW-j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[DV0+j])
				dv_s[j] <= dv_d[j];
		end
	end

	// output stage: sign and clamp of the quotients
	always_comb begin
		dv_t                    f;
		logic [cau_pkg::DW:0]   nq_re;
		logic [cau_pkg::DW:0]   nq_im;
		logic                   sr;
		logic                   si;
		logic signed [cau_pkg::DW-1:0] vr;
		logic signed [cau_pkg::DW-1:0] vi;
		f     = dv_s[cau_pkg::QW];
		nq_re = -{1'b0, f.q_re};
		nq_im = -{1'b0, f.q_im};
		if (f.neg_re) begin
			sr = f.ovf_re || (f.q_re > 16'd32768);
			vr = sr ? 16'sh8000 : nq_re[cau_pkg::DW-1:0];
		end else begin
			sr = f.ovf_re || (f.q_re > 16'd32767);
			vr = sr ? 16'sh7fff : f.q_re;
		end
		if (f.neg_im) begin
			si = f.ovf_im || (f.q_im > 16'd32768);
			vi = si ? 16'sh8000 : nq_im[cau_pkg::DW-1:0];
		end else begin
			si = f.ovf_im || (f.q_im > 16'd32767);
			vi = si ? 16'sh7fff : f.q_im;
		end
		out_d.res_re    = f.res_re;
		out_d.res_im    = f.res_im;
		out_d.equal     = f.equal;
		out_d.div_zero  = f.div_zero;
		out_d.saturated = f.saturated;
		if ((f.cmd == cau_pkg::CMD_DIV) && !f.div_zero) begin
			out_d.res_re    = vr;
			out_d.res_im    = vi;
			out_d.saturated = sr | si;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy[0])
			st_s1 <= st1_d;
		if (rdy[1])
			st_s2 <= st2_d;
		if (rdy[2])
			st_s3 <= st3_d;
		if (rdy[NS-1])
			out_q <= out_d;
	end

	// checks
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_zero |->
		out_data.res_re == 16'sd0 && out_data.res_im == 16'sd0 && !out_data.saturated)
		else $error("divide by zero result not zero");

	a_eq_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.equal |-> !out_data.saturated && !out_data.div_zero)
		else $error("equal flag with other flags");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
		out_data.res_re == 16'sh7fff || out_data.res_re == 16'sh8000 ||
		out_data.res_im == 16'sh7fff || out_data.res_im == 16'sh8000)
		else $error("saturated flag without a clamped part");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item not in first stage");

endmodule
`default_nettype wire

@@ dv/complex_arithmetic_unit_tb.sv @@
// Self-checking testbench for complex_arithmetic_unit: drives operand pairs,
// predicts each result in place and compares it. Depends on cau_pkg and the RTL.
`default_nettype none
module complex_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	cau_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	cau_pkg::out_item_t out_data;

	complex_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #1 clk = ~clk;

	cau_pkg::in_item_t  pending_ops[$];
	cau_pkg::out_item_t expected_results[$];
	int        n_errors = 0;
	int        n_checked = 0;
	int        n_sent = 0;
	bit        calm = 1'b0;      // no idling in the last part
	int        hold_cycles = 0;  // long receiver hold-off
	bit        backpressure_on = 1'b0;

	// clamp to signed 16 bits, flag any clamping
	function automatic logic signed [15:0] clamp_part(longint v, ref bit sat);
		if (v > 32767) begin
			sat = 1'b1;
			return 16'sd32767;
		end
		if (v < -32768) begin
			sat = 1'b1;
			return -16'sd32768;
		end
		return v[15:0];
	endfunction

	// ties-away-from-zero quotient of num*2^F over den
	function automatic longint div_part(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = ((mag <<< (cau_pkg::FRAC_BITS + 1)) + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic cau_pkg::out_item_t compute_result(cau_pkg::in_item_t op);
		cau_pkg::out_item_t r;
		longint ar, ai, br, bi, den;
		bit sat;
		ar = op.a_re;
		ai = op.a_im;
		br = op.b_re;
		bi = op.b_im;
		sat = 1'b0;
		r = '0;
		case (op.cmd)
			cau_pkg::CMD_ADD: begin
				r.res_re = clamp_part(ar + br, sat);
				r.res_im = clamp_part(ai + bi, sat);
			end
			cau_pkg::CMD_SUB: begin
				r.res_re = clamp_part(ar - br, sat);
				r.res_im = clamp_part(ai - bi, sat);
			end
			cau_pkg::CMD_MUL: begin
				// arithmetic shift is floor: round half up
				r.res_re = clamp_part((ar*br - ai*bi +
					(64'sd1 <<< (cau_pkg::FRAC_BITS-1))) >>> cau_pkg::FRAC_BITS, sat);
				r.res_im = clamp_part((ar*bi + ai*br +
					(64'sd1 <<< (cau_pkg::FRAC_BITS-1))) >>> cau_pkg::FRAC_BITS, sat);
			end
			cau_pkg::CMD_DIV: begin
				den = br*br + bi*bi;
				if (den == 0) begin
					r.div_zero = 1'b1;
				end else begin
					r.res_re = clamp_part(div_part(ar*br + ai*bi, den), sat);
					r.res_im = clamp_part(div_part(ai*br - ar*bi, den), sat);
				end
			end
			cau_pkg::CMD_CMP: begin
				r.equal = (ar == br) && (ai == bi);
			end
			default: begin
			end
		endcase
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic [15:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'($signed($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: offer items from the queue with random gap bursts
	int gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_results.push_back(compute_result(in_data));
			n_sent++;
		end
		if (!in_valid || in_ready) begin
			if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() > 0 && arst_n) begin
				in_valid <= 1'b1;
				in_data <= pending_ops.pop_front();
				if (!calm && $urandom_range(0, 9) == 0)
					gap = $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each result, stall with random bursts
	int stall = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no expected item pending");
				n_errors++;
			end else begin
				cau_pkg::out_item_t e;
				e = expected_results.pop_front();
				n_checked++;
				if (out_data.res_re !== e.res_re) begin
					$error("res_re exp %0d got %0d", e.res_re, out_data.res_re);
					n_errors++;
				end
				if (out_data.res_im !== e.res_im) begin
					$error("res_im exp %0d got %0d", e.res_im, out_data.res_im);
					n_errors++;
				end
				if (out_data.equal !== e.equal) begin
					$error("equal exp %0b got %0b", e.equal, out_data.equal);
					n_errors++;
				end
				if (out_data.div_zero !== e.div_zero) begin
					$error("div_zero exp %0b got %0b", e.div_zero, out_data.div_zero);
					n_errors++;
				end
				if (out_data.saturated !== e.saturated) begin
					$error("saturated exp %0b got %0b", e.saturated, out_data.saturated);
					n_errors++;
				end
			end
		end
		if (backpressure_on && hold_cycles < 200) begin
			hold_cycles++;
			out_ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall = $urandom_range(1, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic add_op(logic [2:0] c, logic [15:0] ar, logic [15:0] ai,
		logic [15:0] br, logic [15:0] bi);
		cau_pkg::in_item_t op;
		op.cmd = c;
		op.a_re = ar;
		op.a_im = ai;
		op.b_re = br;
		op.b_im = bi;
		pending_ops.push_back(op);
	endtask

	// stimulus
	initial begin
		logic [2:0] c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, every command, zero divisor, equality, unused codes
		add_op(cau_pkg::CMD_ADD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		add_op(cau_pkg::CMD_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		add_op(cau_pkg::CMD_ADD, 16'h0100, 16'hFF00, 16'h0080, 16'h0040);
		add_op(cau_pkg::CMD_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
		add_op(cau_pkg::CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_op(cau_pkg::CMD_MUL, 16'h0180, 16'hFF80, 16'h0001, 16'h0001);
		add_op(cau_pkg::CMD_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		add_op(cau_pkg::CMD_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
		add_op(cau_pkg::CMD_DIV, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
		add_op(cau_pkg::CMD_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
		add_op(cau_pkg::CMD_DIV, 16'hFF00, 16'h0000, 16'h0300, 16'h0000);
		add_op(cau_pkg::CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		add_op(cau_pkg::CMD_DIV, 16'h0001, 16'h0000, 16'h7FFF, 16'h7FFF);
		add_op(cau_pkg::CMD_CMP, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
		add_op(cau_pkg::CMD_CMP, 16'h1234, 16'h8000, 16'h1234, 16'h8001);
		add_op(cau_pkg::CMD_CMP, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
		add_op(3'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_op(3'd6, 16'h8000, 16'h0001, 16'h0002, 16'h0003);
		add_op(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// random part; the long hold-off starts a little way in
		for (int i = 0; i < 1900; i++) begin
			c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			if (c == cau_pkg::CMD_CMP && $urandom_range(0, 1)) begin
				logic [15:0] x, y;
				x = rand_part();
				y = rand_part();
				add_op(c, x, y, x, $urandom_range(0, 1) ? y : rand_part());
			end else if (c == cau_pkg::CMD_DIV && $urandom_range(0, 15) == 0) begin
				add_op(c, rand_part(), rand_part(), 16'h0000, 16'h0000);
			end else begin
				add_op(c, rand_part(), rand_part(), rand_part(), rand_part());
			end
		end
		wait (n_sent >= 100);
		backpressure_on = 1'b1;
		wait (pending_ops.size() < 300);
		calm = 1'b1;
		wait (pending_ops.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		$display("Checked %0d results over all five commands, unused codes, zero",
			n_checked);
		$display("divisors and saturation, with random stalls and a long hold-off.");
		if (n_errors == 0 && expected_results.size() == 0)
			$display("complex_arithmetic_unit_tb: PASS");
		else
			$display("complex_arithmetic_unit_tb: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("complex_arithmetic_unit_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
